@@ rtl/mar_pkg.sv @@
// Shared constants and types for the moving average ring.
`default_nettype none
package mar_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int TOTAL_W    = SAMPLE_W + ADDR_W;
  localparam int STEP_W     = $clog2(TOTAL_W);
  localparam int WINDOW_RST = 64;

  typedef struct packed {
    logic                      done;
    logic signed [TOTAL_W-1:0] total;
    logic [CNT_W-1:0]          fill;
  } ring_status_t;

endpackage
`default_nettype wire

@@ rtl/mar_ring.sv @@
// Ring buffer store with running total, write position and fill count.
`default_nettype none
module mar_ring (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            clear,
  input  wire logic                            step,
  input  wire logic signed [mar_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [mar_pkg::CNT_W-1:0]       size,
  output mar_pkg::ring_status_t                status
);

  logic signed [mar_pkg::SAMPLE_W-1:0] mem [mar_pkg::WINDOW_MAX];
  logic signed [mar_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [mar_pkg::SAMPLE_W-1:0] sample_q;
  logic signed [mar_pkg::SAMPLE_W-1:0] old_word;
  logic signed [mar_pkg::TOTAL_W-1:0]  total;
  logic signed [mar_pkg::TOTAL_W-1:0]  total_next;
  logic [mar_pkg::ADDR_W-1:0]          wp;
  logic [mar_pkg::ADDR_W-1:0]          wp_next;
  logic [mar_pkg::CNT_W-1:0]           fc;
  logic [mar_pkg::CNT_W-1:0]           fc_next;
  logic                                upd;
  logic                                done;

  // entries at or past the fill count were not written since the last clear
  always_comb begin
    old_word   = (fc < size) ? '0 : rd_data;
    total_next = total
               + {{(mar_pkg::TOTAL_W-mar_pkg::SAMPLE_W){sample_q[mar_pkg::SAMPLE_W-1]}},
                  sample_q}
               - {{(mar_pkg::TOTAL_W-mar_pkg::SAMPLE_W){old_word[mar_pkg::SAMPLE_W-1]}},
                  old_word};
    fc_next    = (fc < size) ? fc + mar_pkg::CNT_W'(1) : fc;
    wp_next    = (({1'b0, wp} + mar_pkg::CNT_W'(1)) >= size) ? '0
               : wp + mar_pkg::ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      mem[wp] <= sample_q;
    end
    rd_data <= mem[wp];
    if (step) begin
      sample_q <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      total <= '0;
      wp    <= '0;
      fc    <= '0;
      upd   <= 1'b0;
      done  <= 1'b0;
    end else begin
      upd  <= step;
      done <= upd;
      if (upd) begin
        total <= total_next;
        wp    <= wp_next;
        fc    <= fc_next;
      end
    end
  end

  assign status.done  = done;
  assign status.total = total;
  assign status.fill  = fc;

endmodule
`default_nettype wire

@@ rtl/mar_div.sv @@
// Bit-serial restoring divider: signed total by fill count, toward zero.
`default_nettype none
module mar_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [mar_pkg::TOTAL_W-1:0] dividend,
  input  wire logic [mar_pkg::CNT_W-1:0]          divisor,
  input  wire logic                               take,
  output logic                                    res_valid,
  output logic signed [mar_pkg::SAMPLE_W-1:0]     quotient
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_DONE = 3'b100
  } div_state_t;

  div_state_t                  state;
  logic [mar_pkg::TOTAL_W-1:0] q;
  logic [mar_pkg::TOTAL_W-1:0] q_neg;
  logic [mar_pkg::CNT_W-1:0]   dvs;
  logic [mar_pkg::CNT_W-1:0]   rem;
  logic [mar_pkg::CNT_W:0]     trial;
  logic [mar_pkg::CNT_W:0]     diff;
  logic                        qbit;
  logic                        neg;
  logic [mar_pkg::STEP_W-1:0]  cnt;

  // one quotient bit per cycle; dividend bits shift out as quotient bits shift in
  always_comb begin
    trial = {rem, q[mar_pkg::TOTAL_W-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
    q_neg = '0 - q;
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        if (start) begin
          q   <= dividend[mar_pkg::TOTAL_W-1] ? mar_pkg::TOTAL_W'(-dividend)
                                               : mar_pkg::TOTAL_W'(dividend);
          neg <= dividend[mar_pkg::TOTAL_W-1];
          dvs <= divisor;
          rem <= '0;
        end
      end
      D_RUN: begin
        rem <= qbit ? diff[mar_pkg::CNT_W-1:0] : trial[mar_pkg::CNT_W-1:0];
        q   <= {q[mar_pkg::TOTAL_W-2:0], qbit};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            state <= D_RUN;
            cnt   <= '0;
          end
        end
        D_RUN: begin
          cnt <= cnt + mar_pkg::STEP_W'(1);
          if (cnt == mar_pkg::STEP_W'(mar_pkg::TOTAL_W - 1)) begin
            state <= D_DONE;
          end
        end
        D_DONE: begin
          if (take) begin
            state <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state == D_DONE);
  assign quotient  = neg ? q_neg[mar_pkg::SAMPLE_W-1:0] : q[mar_pkg::SAMPLE_W-1:0];

endmodule
`default_nettype wire

@@ rtl/moving_average_ring.sv @@
// Top level of the moving average ring: handshakes, window register, control.
//
// Usage notes:
// - Input channel: sample_valid / sample_ready / sample. A word is taken when
//   valid and ready are both high. One word is in work at a time.
// - Output channel: result_valid / result_ready / average / samples_held.
//   One result word per sample, held in an output register until taken.
// - Configuration: cfg_wr_en writes cfg_wr_data into window_size (7 bits) and
//   empties the window (total, fill count, write position). Write only idle.
//   Size zero acts as one; sizes above 64 act as 64.
// - Sequence from sample accept to result_valid: total update (buffer read
//   happens on the accept edge), divider load, bit-serial divide (one quotient
//   bit per cycle), then handoff to the output register. A new sample is not
//   taken until the divider result has been handed off.
// - Stall: if the result register is still full, the divider holds its result
//   until result_ready frees it; sample_ready stays low until then. A new
//   sample may be taken while a finished result waits in the output register.
// - Reset (rst, synchronous): window size 64, window empty, no result pending.
`default_nettype none
module moving_average_ring (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mar_pkg::CNT_W-1:0]           cfg_wr_data,
  input  wire logic                                sample_valid,
  output logic                                     sample_ready,
  input  wire logic signed [mar_pkg::SAMPLE_W-1:0] sample,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic signed [mar_pkg::SAMPLE_W-1:0]      average,
  output logic [mar_pkg::CNT_W-1:0]                samples_held
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RING = 3'b010,
    S_DIV  = 3'b100
  } ctl_state_t;

  ctl_state_t                          state;
  logic [mar_pkg::CNT_W-1:0]           window_size;
  logic [mar_pkg::CNT_W-1:0]           size_eff;
  logic [mar_pkg::CNT_W-1:0]           fill_hold;
  mar_pkg::ring_status_t               ring_st;
  logic                                step;
  logic                                div_start;
  logic                                div_valid;
  logic                                div_take;
  logic signed [mar_pkg::SAMPLE_W-1:0] div_q;

  // zero means one sample, anything past the store depth saturates
  always_comb begin
    if (window_size == '0) begin
      size_eff = mar_pkg::CNT_W'(1);
    end else if (window_size > mar_pkg::CNT_W'(mar_pkg::WINDOW_MAX)) begin
      size_eff = mar_pkg::CNT_W'(mar_pkg::WINDOW_MAX);
    end else begin
      size_eff = window_size;
    end
  end

  assign sample_ready = (state == S_IDLE);
  assign step         = sample_valid && sample_ready;
  assign div_start    = (state == S_RING) && ring_st.done;
  // output register frees up on the same edge it is taken
  assign div_take     = (state == S_DIV) && div_valid && (!result_valid || result_ready);

  mar_ring u_ring (
    .clk    (clk),
    .rst    (rst),
    .clear  (cfg_wr_en),
    .step   (step),
    .sample (sample),
    .size   (size_eff),
    .status (ring_st)
  );

  mar_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (ring_st.total),
    .divisor   (ring_st.fill),
    .take      (div_take),
    .res_valid (div_valid),
    .quotient  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= mar_pkg::CNT_W'(mar_pkg::WINDOW_RST);
    end else if (cfg_wr_en) begin
      window_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (step) begin
            state <= S_RING;
          end
        end
        S_RING: begin
          if (ring_st.done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // fill count goes with the divide it feeds
  always_ff @(posedge clk) begin
    if (div_start) begin
      fill_hold <= ring_st.fill;
    end
    if (div_take) begin
      average      <= div_q;
      samples_held <= fill_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (div_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire
